// ===== sv/mmq_pkg.sv =====
// Shared constants and operation codes of the mailbox message queue engine.
// No dependencies; used by the channel interfaces, the engine and the bench.
`default_nettype none
package mmq_pkg;

  localparam int MSG_SLOTS = 16;
  localparam int BOX_COUNT = 8;
  localparam int MSG_BYTES = 32;

  localparam int OP_W   = 2;
  localparam int PID_W  = 16;
  localparam int BYTE_W = 8;
  localparam int MAXL_W = 7;
  localparam int MLEN_W = 6;

  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEND    = 2'd1;
  localparam logic [OP_W-1:0] OP_RECEIVE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage
`default_nettype wire

// ===== sv/mmq_if.sv =====
// Request and result channel interfaces of the mailbox engine.
// Depends on mmq_pkg for the field widths.
`default_nettype none
interface mmq_req_if
  import mmq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PID_W-1:0]  target_pid;
  logic [PID_W-1:0]  caller_pid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_byte_valid;
  logic              last_byte;
  logic [MAXL_W-1:0] rx_limit;

  modport source (output valid, operation, target_pid, caller_pid, in_byte, in_byte_valid,
                  last_byte, rx_limit, input ready);
  modport sink (input valid, operation, target_pid, caller_pid, in_byte, in_byte_valid,
                last_byte, rx_limit, output ready);
endinterface

interface mmq_res_if
  import mmq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              status;
  logic [PID_W-1:0]  src_pid;
  logic [MLEN_W-1:0] msg_length;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid;
  logic              last_result;

  modport source (output valid, status, src_pid, msg_length, out_byte, out_byte_valid,
                  last_result, input ready);
  modport sink (input valid, status, src_pid, msg_length, out_byte, out_byte_valid,
                last_result, output ready);
endinterface
`default_nettype wire

// ===== sv/mmq_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module mmq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/mailbox_message_queue_engine_unit.sv =====
// Top level of the mailbox message queue engine.
// Depends on mmq_pkg, mmq_req_if, mmq_res_if and mmq_ram.
//
// Requests arrive on req_i and results leave on res_o, both valid/ready.
// Create gives one result in the cycle after it is taken. A send request
// not marked last gives no result and the next request may follow at once,
// so bytes stream at one per cycle while the result register has room. A last
// send gives its result in the cycle after it is taken; when it appends
// behind an existing message the link state then updates the link memory.
// Receive reads the slot's link, sender and length in the cycle after it is
// taken, in the metadata state, then gives its bytes from the byte state one
// per cycle while the receiver takes them. The engine's memories have
// registered read data. Requests are taken only while no request is in
// progress and the result register is free or being emptied. When the
// receiver stalls, the result is held and the byte stream waits. Reset empties
// all mailboxes and slots at once; no clearing pass is needed.
`default_nettype none
module mailbox_message_queue_engine_unit
  import mmq_pkg::*;
#(
  parameter int MsgSlots = MSG_SLOTS,
  parameter int BoxCount = BOX_COUNT,
  parameter int MsgBytes = MSG_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mmq_req_if.sink   req_i,
  mmq_res_if.source res_o
);

  localparam int IW  = (MsgSlots > 1) ? $clog2(MsgSlots) : 1;
  localparam int SW  = $clog2(MsgSlots + 1);
  localparam int BW  = (BoxCount > 1) ? $clog2(BoxCount) : 1;
  localparam int CW  = $clog2(MsgBytes + 1);
  localparam int BYD = MsgSlots * MsgBytes;
  localparam int BAW = (BYD > 1) ? $clog2(BYD) : 1;
  localparam logic [SW-1:0] NIL = SW'(MsgSlots);

  typedef enum logic [1:0] {ST_IDLE, ST_LINK, ST_RX_META, ST_RX_BYTES} state_e;

  state_e state_q;
  logic [MsgSlots-1:0]     slot_used_q;
  logic [BoxCount-1:0]     box_used_q;
  logic [PID_W-1:0]        box_owner_q [BoxCount];
  logic [SW-1:0]           box_head_q  [BoxCount];
  logic [SW-1:0]           box_tail_q  [BoxCount];
  logic                    send_active_q;
  logic [SW-1:0]           send_slot_q;
  logic [CW-1:0]           send_count_q;
  logic [IW-1:0]           link_tail_q, link_slot_q;
  logic [BW-1:0]           rx_box_q;
  logic [IW-1:0]           rx_slot_q;
  logic [MAXL_W-1:0]       rx_max_q;
  logic [CW-1:0]           rx_n_q, rx_k_q, rx_len_q;
  logic [PID_W-1:0]        rx_sender_q;

  logic              out_valid_q, out_status_q, out_bvalid_q, out_last_q;
  logic [PID_W-1:0]  out_sender_q;
  logic [MLEN_W-1:0] out_len_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic out_free, accept;
  assign out_free = !out_valid_q || res_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept = req_i.valid && req_i.ready;

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = out_status_q;
  assign res_o.src_pid        = out_sender_q;
  assign res_o.msg_length     = out_len_q;
  assign res_o.out_byte       = out_byte_q;
  assign res_o.out_byte_valid = out_bvalid_q;
  assign res_o.last_result    = out_last_q;

  logic          free_slot_ok, free_box_ok, send_box_ok, rx_box_ok;
  logic [IW-1:0] free_slot;
  logic [BW-1:0] free_box, send_box, rx_box;

  always_comb begin
    free_slot_ok = 1'b0;
    free_slot    = '0;
    for (int i = MsgSlots - 1; i >= 0; i--) begin
      if (!slot_used_q[i]) begin
        free_slot_ok = 1'b1;
        free_slot    = IW'(i);
      end
    end
    free_box_ok = 1'b0;
    free_box    = '0;
    send_box_ok = 1'b0;
    send_box    = '0;
    rx_box_ok   = 1'b0;
    rx_box      = '0;
    for (int i = BoxCount - 1; i >= 0; i--) begin
      if (!box_used_q[i]) begin
        free_box_ok = 1'b1;
        free_box    = BW'(i);
      end
      if (box_used_q[i] && box_owner_q[i] == req_i.target_pid) begin
        send_box_ok = 1'b1;
        send_box    = BW'(i);
        if (box_head_q[i] != NIL) begin
          rx_box_ok = 1'b1;
          rx_box    = BW'(i);
        end
      end
    end
  end

  logic [SW-1:0] cur_slot;
  logic [CW-1:0] cnt_base, cnt_new;
  logic          byte_we, cur_ok;
  assign cur_slot = send_active_q ? send_slot_q : (free_slot_ok ? SW'(free_slot) : NIL);
  assign cur_ok   = (cur_slot != NIL);
  assign cnt_base = send_active_q ? send_count_q : '0;
  assign byte_we  = accept && (req_i.operation == OP_SEND) && req_i.in_byte_valid && cur_ok
                    && (cnt_base < CW'(MsgBytes));
  assign cnt_new  = byte_we ? cnt_base + CW'(1) : cnt_base;

  logic send_last, send_claim;
  assign send_last  = accept && (req_i.operation == OP_SEND) && req_i.last_byte;
  assign send_claim = accept && (req_i.operation == OP_SEND) && !send_active_q && free_slot_ok;

  logic [SW-1:0]     link_rd;
  logic [PID_W-1:0]  sender_rd;
  logic [CW-1:0]     len_rd;
  logic [BYTE_W-1:0] byte_rd;
  logic [IW-1:0]     meta_raddr;
  logic [SW-1:0]     rx_head;
  assign rx_head    = box_head_q[rx_box];
  assign meta_raddr = rx_head[IW-1:0];

  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [SW-1:0] link_wdata;
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_slot[IW-1:0];
    link_wdata = NIL;
    if (state_q == ST_LINK) begin
      link_we    = 1'b1;
      link_waddr = link_tail_q;
      link_wdata = SW'(link_slot_q);
    end else if (send_last && cur_ok && send_box_ok) begin
      link_we = 1'b1;
    end
  end

  logic          rx_adv;
  logic [CW-1:0] rd_k;
  logic [BAW-1:0] byte_raddr, byte_waddr;
  assign rx_adv     = (state_q == ST_RX_BYTES) && out_free;
  assign rd_k       = (state_q == ST_RX_BYTES) ? (rx_adv ? rx_k_q + CW'(1) : rx_k_q) : '0;
  assign byte_raddr = BAW'(rx_slot_q) * BAW'(MsgBytes) + BAW'(rd_k);
  assign byte_waddr = BAW'(cur_slot[IW-1:0]) * BAW'(MsgBytes) + BAW'(cnt_base);

  mmq_ram #(.Width(SW), .Depth(MsgSlots)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(meta_raddr), .rdata_o(link_rd)
  );
  mmq_ram #(.Width(PID_W), .Depth(MsgSlots)) u_sender_ram (
    .clk_i, .we_i(send_claim), .waddr_i(free_slot), .wdata_i(req_i.caller_pid),
    .raddr_i(meta_raddr), .rdata_o(sender_rd)
  );
  mmq_ram #(.Width(CW), .Depth(MsgSlots)) u_len_ram (
    .clk_i, .we_i(send_last && cur_ok), .waddr_i(cur_slot[IW-1:0]), .wdata_i(cnt_new),
    .raddr_i(meta_raddr), .rdata_o(len_rd)
  );
  mmq_ram #(.Width(BYTE_W), .Depth(BYD)) u_byte_ram (
    .clk_i, .we_i(byte_we), .waddr_i(byte_waddr), .wdata_i(req_i.in_byte),
    .raddr_i(byte_raddr), .rdata_o(byte_rd)
  );

  logic [CW-1:0]     meta_len, meta_n;
  logic [MAXL_W:0]   len_wide;
  logic [MAXL_W:0]   rxlen_wide;
  assign meta_len   = (len_rd > CW'(MsgBytes)) ? CW'(MsgBytes) : len_rd;
  assign len_wide   = (MAXL_W + 1)'(meta_len);
  assign meta_n     = (len_wide < (MAXL_W + 1)'(rx_max_q)) ? meta_len : CW'(rx_max_q);
  assign rxlen_wide = (MAXL_W + 1)'(rx_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      slot_used_q   <= '0;
      box_used_q    <= '0;
      send_active_q <= 1'b0;
      send_slot_q   <= '0;
      send_count_q  <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < BoxCount; i++) begin
        box_head_q[i] <= NIL;
        box_tail_q[i] <= NIL;
      end
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_status_q <= STATUS_FAIL;
            out_sender_q <= '0;
            out_len_q    <= '0;
            out_byte_q   <= '0;
            out_bvalid_q <= 1'b0;
            out_last_q   <= 1'b1;
            case (req_i.operation)
              OP_CREATE: begin
                out_valid_q <= 1'b1;
                if (free_box_ok) begin
                  out_status_q           <= STATUS_OK;
                  box_used_q[free_box]   <= 1'b1;
                  box_owner_q[free_box]  <= req_i.target_pid;
                  box_head_q[free_box]   <= NIL;
                  box_tail_q[free_box]   <= NIL;
                end
              end
              OP_SEND: begin
                send_active_q <= !req_i.last_byte;
                send_slot_q   <= cur_slot;
                send_count_q  <= cnt_new;
                if (send_claim) begin
                  slot_used_q[free_slot] <= 1'b1;
                end
                if (req_i.last_byte) begin
                  out_valid_q <= 1'b1;
                  if (cur_ok) begin
                    if (!send_box_ok) begin
                      slot_used_q[cur_slot[IW-1:0]] <= 1'b0;
                    end else begin
                      out_status_q         <= STATUS_OK;
                      box_tail_q[send_box] <= cur_slot;
                      if (box_tail_q[send_box] == NIL) begin
                        box_head_q[send_box] <= cur_slot;
                      end else begin
                        link_tail_q <= box_tail_q[send_box][IW-1:0];
                        link_slot_q <= cur_slot[IW-1:0];
                        state_q     <= ST_LINK;
                      end
                    end
                  end
                end
              end
              OP_RECEIVE: begin
                if (rx_box_ok) begin
                  rx_box_q  <= rx_box;
                  rx_slot_q <= rx_head[IW-1:0];
                  rx_max_q  <= req_i.rx_limit;
                  state_q   <= ST_RX_META;
                end else begin
                  out_valid_q <= 1'b1;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_LINK: begin
          state_q <= ST_IDLE;
        end
        ST_RX_META: begin
          slot_used_q[rx_slot_q] <= 1'b0;
          if (link_rd >= SW'(MsgSlots)) begin
            box_head_q[rx_box_q] <= NIL;
            box_tail_q[rx_box_q] <= NIL;
          end else begin
            box_head_q[rx_box_q] <= link_rd;
          end
          rx_sender_q <= sender_rd;
          rx_len_q    <= meta_len;
          rx_n_q      <= meta_n;
          rx_k_q      <= '0;
          if (meta_n == '0) begin
            out_valid_q  <= 1'b1;
            out_status_q <= STATUS_OK;
            out_sender_q <= sender_rd;
            out_len_q    <= len_wide[MLEN_W-1:0];
            out_byte_q   <= '0;
            out_bvalid_q <= 1'b0;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end else begin
            state_q <= ST_RX_BYTES;
          end
        end
        ST_RX_BYTES: begin
          if (rx_adv) begin
            out_valid_q  <= 1'b1;
            out_status_q <= STATUS_OK;
            out_sender_q <= rx_sender_q;
            out_len_q    <= rxlen_wide[MLEN_W-1:0];
            out_byte_q   <= byte_rd;
            out_bvalid_q <= 1'b1;
            out_last_q   <= (rx_k_q + CW'(1) == rx_n_q);
            rx_k_q       <= rx_k_q + CW'(1);
            if (rx_k_q + CW'(1) == rx_n_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!res_o.valid || res_o.ready))
    else $error("request taken while a result is stalled");

  a_link_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LINK |=> state_q == ST_IDLE)
    else $error("link update did not finish in one cycle");

  a_byte_is_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.out_byte_valid) |-> (res_o.status == STATUS_OK))
    else $error("data byte delivered with failure status");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for mailbox_message_queue_engine_unit: directed requests, then random
// message traffic, all checked against a mailbox and slot pool predictor kept in the bench.
// Depends on mmq_pkg, mmq_req_if, mmq_res_if and the engine RTL.
`timescale 1ns / 100ps
module tb;
  import mmq_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  target;
    logic [PID_W-1:0]  caller;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic              last;
    logic [MAXL_W-1:0] max_len;
  } request_t;

  typedef struct packed {
    logic              status;
    logic [PID_W-1:0]  sender;
    logic [MLEN_W-1:0] length;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic              last;
  } outcome_t;

  typedef struct {
    request_t req;
    bit       typed;
    logic     status;
  } row_t;

  localparam logic [4:0] NIL = 5'(MSG_SLOTS);
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic clk_i;
  logic rst_ni;
  mmq_req_if req ();
  mmq_res_if res ();

  mailbox_message_queue_engine_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res)
  );

  // Predictor state.
  logic              slot_used [MSG_SLOTS];
  logic [4:0]        slot_next [MSG_SLOTS];
  logic [PID_W-1:0]  slot_from [MSG_SLOTS];
  logic [MLEN_W-1:0] slot_len  [MSG_SLOTS];
  logic [BYTE_W-1:0] slot_data [MSG_SLOTS][MSG_BYTES];
  logic              box_used  [BOX_COUNT];
  logic [PID_W-1:0]  box_pid   [BOX_COUNT];
  logic [4:0]        box_first [BOX_COUNT];
  logic [4:0]        box_last  [BOX_COUNT];
  logic              msg_open;
  logic [4:0]        msg_slot;
  int                msg_count;

  outcome_t pending_results[$];
  row_t     stimulus_table[$];
  logic [PID_W-1:0] owners[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_req = 0;
  int hold_left = 0;

  function automatic outcome_t plain(logic st);
    outcome_t o;
    o = '0;
    o.status = st;
    o.last = 1'b1;
    return o;
  endfunction

  function automatic int find_mailbox(logic [PID_W-1:0] pid, bit need_msg);
    for (int i = 0; i < BOX_COUNT; i++) begin
      if (box_used[i] && box_pid[i] == pid && (!need_msg || box_first[i] != NIL)) return i;
    end
    return -1;
  endfunction

  function automatic void mailbox_predict(request_t r, bit typed, logic st);
    int bx;
    int n;
    logic [4:0] s;
    outcome_t o;
    outcome_t got[$];
    case (r.op)
      OP_CREATE: begin
        bx = -1;
        for (int i = 0; i < BOX_COUNT; i++) begin
          if (!box_used[i] && bx < 0) bx = i;
        end
        if (bx >= 0) begin
          box_used[bx] = 1'b1;
          box_pid[bx] = r.target;
          box_first[bx] = NIL;
          box_last[bx] = NIL;
        end
        got.push_back(plain(bx < 0 ? STATUS_FAIL : STATUS_OK));
      end
      OP_SEND: begin
        if (!msg_open) begin
          msg_open = 1'b1;
          msg_slot = NIL;
          msg_count = 0;
          for (int i = 0; i < MSG_SLOTS; i++) begin
            if (!slot_used[i] && msg_slot == NIL) begin
              slot_used[i] = 1'b1;
              slot_next[i] = NIL;
              slot_from[i] = r.caller;
              msg_slot = 5'(i);
            end
          end
        end
        s = msg_slot;
        if (r.data_valid && s != NIL && msg_count < MSG_BYTES) begin
          slot_data[s][msg_count] = r.data;
          msg_count++;
        end
        if (r.last) begin
          msg_open = 1'b0;
          if (s == NIL) begin
            got.push_back(plain(STATUS_FAIL));
          end else begin
            slot_len[s] = MLEN_W'(msg_count);
            bx = find_mailbox(r.target, 0);
            slot_next[s] = NIL;
            if (bx < 0) begin
              slot_used[s] = 1'b0;
              got.push_back(plain(STATUS_FAIL));
            end else begin
              if (box_last[bx] != NIL) slot_next[box_last[bx]] = s;
              else box_first[bx] = s;
              box_last[bx] = s;
              got.push_back(plain(STATUS_OK));
            end
          end
        end
      end
      OP_RECEIVE: begin
        bx = find_mailbox(r.target, 1);
        if (bx < 0) begin
          got.push_back(plain(STATUS_FAIL));
        end else begin
          s = box_first[bx];
          box_first[bx] = slot_next[s];
          if (box_first[bx] == NIL) box_last[bx] = NIL;
          n = (slot_len[s] < r.max_len) ? int'(slot_len[s]) : int'(r.max_len);
          o = '0;
          o.sender = slot_from[s];
          o.length = slot_len[s];
          if (n == 0) begin
            o.last = 1'b1;
            got.push_back(o);
          end else begin
            for (int k = 0; k < n; k++) begin
              o.data = slot_data[s][k];
              o.data_valid = 1'b1;
              o.last = (k + 1 == n);
              got.push_back(o);
            end
          end
          slot_used[s] = 1'b0;
          slot_next[s] = NIL;
        end
      end
      default: got.push_back(plain(STATUS_FAIL));
    endcase
    if (typed) begin
      got.delete();
      got.push_back(plain(st));
    end
    foreach (got[i]) pending_results.push_back(got[i]);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("mailbox_message_queue_engine_unit regression: fail");
    $finish;
  end

  // Result side: checking, random stalls and the long hold-off.
  initial res.ready = 1'b0;
  always @(posedge clk_i) begin
    outcome_t act;
    outcome_t exp_r;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        act = {res.status, res.src_pid, res.msg_length, res.out_byte,
               res.out_byte_valid, res.last_result};
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0b sender=%h len=%0d byte=%h bv=%0b last=%0b",
                   $time, act.status, act.sender, act.length, act.data, act.data_valid,
                   act.last);
        end else begin
          exp_r = pending_results.pop_front();
          if (act.status !== exp_r.status || act.sender !== exp_r.sender ||
              act.length !== exp_r.length || act.data !== exp_r.data ||
              act.data_valid !== exp_r.data_valid || act.last !== exp_r.last) begin
            errors++;
            $display("%0t: mismatch expected status=%0b sender=%h len=%0d byte=%h bv=%0b last=%0b",
                     $time, exp_r.status, exp_r.sender, exp_r.length, exp_r.data,
                     exp_r.data_valid, exp_r.last);
            $display("%0t:          actual   status=%0b sender=%h len=%0d byte=%h bv=%0b last=%0b",
                     $time, act.status, act.sender, act.length, act.data, act.data_valid,
                     act.last);
          end
        end
      end
      if (hold_off_req != 0) begin
        hold_left = 200;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic offer(request_t r, bit typed = 0, logic st = STATUS_OK);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.operation <= r.op;
    req.target_pid <= r.target;
    req.caller_pid <= r.caller;
    req.in_byte <= r.data;
    req.in_byte_valid <= r.data_valid;
    req.last_byte <= r.last;
    req.rx_limit <= r.max_len;
    do @(posedge clk_i); while (!req.ready);
    n_requests++;
    mailbox_predict(r, typed, st);
  endtask

  function automatic request_t make(logic [OP_W-1:0] op, logic [PID_W-1:0] tp,
                                    logic [PID_W-1:0] cp, logic [BYTE_W-1:0] b,
                                    logic bv, logic lb, logic [MAXL_W-1:0] ml);
    request_t r;
    r.op = op; r.target = tp; r.caller = cp; r.data = b;
    r.data_valid = bv; r.last = lb; r.max_len = ml;
    return r;
  endfunction

  function automatic void add_row(request_t r, bit typed = 0, logic st = STATUS_OK);
    row_t w;
    w.req = r; w.typed = typed; w.status = st;
    stimulus_table.push_back(w);
  endfunction

  function automatic logic [PID_W-1:0] pick_owner();
    if (owners.size() == 0 || $urandom_range(9) == 0) return PID_W'($urandom());
    return owners[$urandom_range(owners.size() - 1)];
  endfunction

  task automatic send_message(logic [PID_W-1:0] dest, int nbytes);
    logic [PID_W-1:0] from;
    from = PID_W'($urandom());
    if (nbytes == 0) begin
      offer(make(OP_SEND, dest, from, BYTE_W'($urandom()), 1'b0, 1'b1, MAXL_W'($urandom())));
    end else begin
      for (int k = 0; k < nbytes; k++) begin
        offer(make(OP_SEND, (k + 1 == nbytes) ? dest : PID_W'($urandom()),
                   (k == 0) ? from : PID_W'($urandom()), BYTE_W'($urandom()),
                   ($urandom_range(19) != 0), (k + 1 == nbytes), MAXL_W'($urandom())));
      end
    end
  endtask

  initial begin
    int len;
    int sel;
    rst_ni = 1'b0;
    req.valid <= 1'b0;
    req.operation <= OP_CREATE;
    req.target_pid <= '0;
    req.caller_pid <= '0;
    req.in_byte <= '0;
    req.in_byte_valid <= 1'b0;
    req.last_byte <= 1'b0;
    req.rx_limit <= '0;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0; slot_next[i] = NIL; slot_from[i] = '0; slot_len[i] = '0;
    end
    foreach (box_used[i]) begin
      box_used[i] = 1'b0; box_pid[i] = '0; box_first[i] = NIL; box_last[i] = NIL;
    end
    msg_open = 1'b0; msg_slot = '0; msg_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(make(OP_RECEIVE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd127), 1, STATUS_FAIL);
    add_row(make(OP_SEND, 16'd5, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 7'd0), 1, STATUS_FAIL);
    add_row(make(OP_CREATE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 7'd127), 1, STATUS_FAIL);
    add_row(make(OP_SEND, 16'd9, 16'hFFFF, 8'h00, 1'b1, 1'b0, 7'd0));
    add_row(make(OP_SEND, 16'd0, 16'h0000, 8'hFF, 1'b1, 1'b0, 7'd127));
    add_row(make(OP_SEND, 16'd5, 16'h1234, 8'hA5, 1'b0, 1'b0, 7'd0));
    add_row(make(OP_SEND, 16'd5, 16'h0000, 8'h5A, 1'b1, 1'b1, 7'd0), 1, STATUS_OK);
    add_row(make(OP_SEND, 16'd5, 16'h0000, 8'h00, 1'b0, 1'b1, 7'd0), 1, STATUS_OK);
    add_row(make(OP_RECEIVE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd127));
    add_row(make(OP_RECEIVE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0));
    add_row(make(OP_RECEIVE, 16'd5, 16'd0, 8'h00, 1'b0, 1'b0, 7'd64), 1, STATUS_FAIL);
    add_row(make(OP_CREATE, 16'h0000, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'hFFFF, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd1, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd2, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd3, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd4, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_OK);
    add_row(make(OP_CREATE, 16'd9, 16'd0, 8'h00, 1'b0, 1'b0, 7'd0), 1, STATUS_FAIL);
    add_row(make(OP_SEND, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 7'd0), 1, STATUS_OK);
    add_row(make(OP_RECEIVE, 16'hFFFF, 16'd0, 8'h00, 1'b0, 1'b0, 7'd127));
    foreach (stimulus_table[i]) offer(stimulus_table[i].req, stimulus_table[i].typed,
                                      stimulus_table[i].status);
    owners = '{16'd5, 16'h0000, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4};

    while (n_requests < 380) begin
      case (n_requests * 4 / 380)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (n_requests > 150 && n_requests < 170 && hold_left == 0) hold_off_req = 1;
      if (n_requests > 250 && n_requests < 260) begin
        req.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end
      sel = $urandom_range(99);
      if (sel < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
        send_message(pick_owner(), len);
      end else if (sel < 85) begin
        offer(make(OP_RECEIVE, pick_owner(), PID_W'($urandom()), BYTE_W'($urandom()),
                   1'($urandom()), 1'($urandom()),
                   ($urandom_range(1) != 0) ? MAXL_W'($urandom()) : MAXL_W'($urandom_range(3))));
      end else if (sel < 90) begin
        offer(make(OP_CREATE, pick_owner(), PID_W'($urandom()), BYTE_W'($urandom()),
                   1'($urandom()), 1'($urandom()), MAXL_W'($urandom())));
      end else begin
        offer(make(($urandom_range(1) != 0) ? OP_UNKNOWN : OP_SEND, PID_W'($urandom()),
                   PID_W'($urandom()), BYTE_W'($urandom()), 1'($urandom()),
                   1'($urandom()), MAXL_W'($urandom())));
      end
    end
    if (msg_open) offer(make(OP_SEND, 16'd5, 16'd0, 8'h00, 1'b0, 1'b1, 7'd0));
    req.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests and %0d results across creates, sends, receives and bad ops,",
             n_requests, n_results);
    $display("with pool and mailbox exhaustion, truncation and idle and stall phases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("mailbox_message_queue_engine_unit regression: pass");
    end else begin
      $display("mailbox_message_queue_engine_unit regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/mmq_pkg.sv
sv/mmq_if.sv
sv/mmq_ram.sv
sv/mailbox_message_queue_engine_unit.sv
bench/tb.sv
